// ----- src/mbre_pkg.sv -----
// shared types and constants of the block record encoder
// no dependencies; imported by every module
`default_nettype none

package mbre_pkg;

	// action codes of an input item
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	localparam int HDR_MAX_BYTES = 23;
	localparam int HDR_BITS      = 8 * HDR_MAX_BYTES;

	localparam logic [7:0] LEAD_RESET = 8'h93;

	// map keys and marker bytes
	localparam logic [7:0] KEY_DEVNO  = 8'h00;
	localparam logic [7:0] KEY_OFFSET = 8'h01;
	localparam logic [7:0] KEY_LENGTH = 8'h02;
	localparam logic [7:0] MK_INT8    = 8'hD0;
	localparam logic [7:0] MK_INT16   = 8'hD1;
	localparam logic [7:0] MK_INT32   = 8'hD2;
	localparam logic [7:0] MK_INT64   = 8'hD3;
	localparam logic [7:0] MK_BIN8    = 8'hC4;
	localparam logic [7:0] MK_BIN16   = 8'hC5;
	localparam logic [7:0] MK_BIN32   = 8'hC6;

	// count of header bytes present whatever the item's values
	localparam logic [4:0] HDR_FIXED_BYTES = 5'd13;

	typedef logic [HDR_BITS-1:0] hdr_vec_t;

	typedef struct packed {
		logic               action;
		logic signed [31:0] device_number;
		logic signed [63:0] block_offset;
		logic [31:0]        payload_length;
		logic [7:0]         payload_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       overflow;
	} result_t;

	// header as built for one start item, first byte in the top bits
	typedef struct packed {
		hdr_vec_t   bytes;
		logic [4:0] count;
	} hdr_t;

endpackage

`default_nettype wire

// ----- src/mbre_ifs.sv -----
// handshake channels of the block record encoder: items in, bytes out, lead byte write
// no dependencies
`default_nettype none

interface mbre_cmd_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] device_number;
	logic signed [63:0] block_offset;
	logic [31:0]        payload_length;
	logic [7:0]         payload_byte;

	modport source (output valid, action, device_number, block_offset, payload_length,
		payload_byte, input ready);
	modport sink (input valid, action, device_number, block_offset, payload_length,
		payload_byte, output ready);
endinterface

interface mbre_enc_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       overflow;

	modport source (output valid, out_byte, last, overflow, input ready);
	modport sink (input valid, out_byte, last, overflow, output ready);
endinterface

interface mbre_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] record_lead_byte;

	modport source (output valid, record_lead_byte, input ready);
	modport sink (input valid, record_lead_byte, output ready);
endinterface

`default_nettype wire

// ----- src/msgpack_block_record_encoder_unit.sv -----
// top level of the block record encoder: input register, lead byte register,
// header builder and byte emitter; depends on mbre_pkg, mbre_ifs, mbre_hdr_build, mbre_emit
`default_nettype none

// channel  role    moves
// cmd      sink    start item (device, offset, length) or one payload byte
// enc      source  one encoded byte with last and overflow flags
// cfg      sink    write of the record lead byte, always ready
//
// a data item moves from the input register to the output register; with the output ready
// items stream at one per cycle, a start item gives 16 to 23 header bytes, one per cycle,
// and the input waits while the header drains from its shift register
// reset clears the valids, the byte counter and sets the lead byte to 0x93
// a stalled output holds its byte; the input register keeps taking one item behind it
module msgpack_block_record_encoder_unit (
	input  logic     clk,
	input  logic     arst_n,
	mbre_cmd_if.sink cmd,
	mbre_enc_if.source enc,
	mbre_cfg_if.sink cfg
);
	import mbre_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	logic [7:0] lead_q;
	hdr_t      hdr;
	logic      take;
	result_t   res;

	// input register is free when empty or being drained this cycle
	assign cmd.ready = !valid_s1 || take;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.action         <= cmd.action;
			item_s1.device_number  <= cmd.device_number;
			item_s1.block_offset   <= cmd.block_offset;
			item_s1.payload_length <= cmd.payload_length;
			item_s1.payload_byte   <= cmd.payload_byte;
		end
	end

	// lead byte; the user must write it only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= LEAD_RESET;
		end else if (cfg.valid) begin
			lead_q <= cfg.record_lead_byte;
		end
	end

	// whole header of a start item, built from the input register
	mbre_hdr_build u_hdr (
		.lead (lead_q),
		.item (item_s1),
		.hdr  (hdr)
	);

	// serializes header bytes and passes payload bytes
	mbre_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.hdr       (hdr),
		.out_ready (enc.ready),
		.take      (take),
		.out_valid (enc.valid),
		.out_res   (res)
	);

	assign enc.out_byte = res.out_byte;
	assign enc.last     = res.last;
	assign enc.overflow = res.overflow;

endmodule

`default_nettype wire

// ----- src/mbre_hdr_build.sv -----
// combinational header builder: lead byte, device number, offset and length header
// depends on mbre_pkg
`default_nettype none

module mbre_hdr_build (
	input  logic [7:0]     lead,
	input  mbre_pkg::item_t item,
	output mbre_pkg::hdr_t  hdr
);
	import mbre_pkg::*;

	logic [31:0]  dev_u;
	logic [39:0]  dev_piece;
	logic [2:0]   dev_len;
	logic [39:0]  bin_piece;
	logic [2:0]   bin_len;
	logic [127:0] tail;
	hdr_vec_t     tail_ext;
	hdr_vec_t     tail_pos;

	assign dev_u = item.device_number;

	// shortest int form of the device number, left-justified
	always_comb begin
		if (dev_u <= 32'h0000_007F || dev_u >= 32'hFFFF_FFE0) begin
			dev_piece = {dev_u[7:0], 32'h0};
			dev_len   = 3'd1;
		end else if (dev_u >= 32'hFFFF_FF80) begin
			dev_piece = {MK_INT8, dev_u[7:0], 24'h0};
			dev_len   = 3'd2;
		end else if (dev_u <= 32'h0000_7FFF || dev_u >= 32'hFFFF_8000) begin
			dev_piece = {MK_INT16, dev_u[15:0], 16'h0};
			dev_len   = 3'd3;
		end else begin
			dev_piece = {MK_INT32, dev_u};
			dev_len   = 3'd5;
		end
	end

	// bin length header, left-justified
	always_comb begin
		if (item.payload_length < 32'd256) begin
			bin_piece = {MK_BIN8, item.payload_length[7:0], 24'h0};
			bin_len   = 3'd2;
		end else if (item.payload_length < 32'd65536) begin
			bin_piece = {MK_BIN16, item.payload_length[15:0], 16'h0};
			bin_len   = 3'd3;
		end else begin
			bin_piece = {MK_BIN32, item.payload_length};
			bin_len   = 3'd5;
		end
	end

	assign tail     = {KEY_OFFSET, MK_INT64, item.block_offset, KEY_LENGTH, bin_piece};
	assign tail_ext = {56'h0, tail};

	// close the gap left by a short device number
	always_comb begin
		case (dev_len)
			3'd1:    tail_pos = tail_ext << 32;
			3'd2:    tail_pos = tail_ext << 24;
			3'd3:    tail_pos = tail_ext << 16;
			default: tail_pos = tail_ext;
		endcase
	end

	assign hdr.bytes = {lead, KEY_DEVNO, dev_piece, 128'h0} | tail_pos;
	assign hdr.count = HDR_FIXED_BYTES + {2'b00, dev_len} + {2'b00, bin_len};

endmodule

`default_nettype wire

// ----- src/mbre_emit.sv -----
// byte emitter: header shift register, payload byte counter and output register
// depends on mbre_pkg
`default_nettype none

module mbre_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  mbre_pkg::item_t  item_s1,
	input  mbre_pkg::hdr_t   hdr,
	input  logic             out_ready,
	output logic             take,
	output logic             out_valid,
	output mbre_pkg::result_t out_res
);
	import mbre_pkg::*;

	logic       out_valid_q;
	result_t    res_q;
	hdr_vec_t   hdr_q;
	logic [4:0] hdr_left_q;
	logic [31:0] rem_q;
	logic       len_zero_q;
	logic       adv;
	logic       hdr_busy;

	assign adv      = !out_valid_q || out_ready;
	assign hdr_busy = hdr_left_q != 5'd0;
	assign take     = valid_s1 && !hdr_busy && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hdr_left_q  <= 5'd0;
			rem_q       <= 32'd0;
			len_zero_q  <= 1'b0;
		end else if (adv) begin
			if (hdr_busy) begin
				out_valid_q <= 1'b1;
				hdr_left_q  <= hdr_left_q - 5'd1;
			end else if (valid_s1) begin
				out_valid_q <= 1'b1;
				if (item_s1.action == ACT_START) begin
					hdr_left_q <= hdr.count - 5'd1;
					rem_q      <= item_s1.payload_length;
					len_zero_q <= item_s1.payload_length == 32'd0;
				end else if (rem_q != 32'd0) begin
					rem_q <= rem_q - 32'd1;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output byte and header shift register, no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			if (hdr_busy) begin
				res_q.out_byte <= hdr_q[HDR_BITS-1 -: 8];
				res_q.last     <= (hdr_left_q == 5'd1) && len_zero_q;
				res_q.overflow <= 1'b0;
				hdr_q          <= hdr_q << 8;
			end else if (valid_s1) begin
				if (item_s1.action == ACT_START) begin
					res_q.out_byte <= hdr.bytes[HDR_BITS-1 -: 8];
					res_q.last     <= 1'b0;
					res_q.overflow <= 1'b0;
					hdr_q          <= hdr.bytes << 8;
				end else if (rem_q == 32'd0) begin
					res_q.out_byte <= 8'h00;
					res_q.last     <= 1'b0;
					res_q.overflow <= 1'b1;
				end else begin
					res_q.out_byte <= item_s1.payload_byte;
					res_q.last     <= rem_q == 32'd1;
					res_q.overflow <= 1'b0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

`ifndef ASSERT_OFF
	a_ovf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.overflow |-> res_q.out_byte == 8'h00 && !res_q.last)
		else $error("overflow result carries data or last");
	a_no_take_in_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_busy |-> !take)
		else $error("item taken while header still draining");
	a_hdr_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_busy |-> out_valid_q)
		else $error("header pending with empty output register");
	a_hdr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_left_q <= 5'd22)
		else $error("header byte count out of range");
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		take && item_s1.action == ACT_START |=> out_valid_q && hdr_left_q >= 5'd15)
		else $error("start item did not load header");
`endif

endmodule

`default_nettype wire

// ----- sim/msgpack_block_record_encoder_unit_tb.sv -----
// self-checking testbench of the block record encoder: drives start and payload items,
// predicts every encoded byte with its own header builder and checks them in order
// depends on mbre_pkg, mbre_ifs and msgpack_block_record_encoder_unit
`timescale 1ns / 1ps

module msgpack_block_record_encoder_unit_tb;
	import mbre_pkg::*;

	localparam int STALL_LIMIT   = 2000;	// cycles with no handshake anywhere
	localparam int HOLD_CYCLES   = 160;	// long output hold-off
	localparam int RANDOM_ITEMS  = 95;
	localparam int SETTLE_CYCLES = 8;	// quiet wait after the last predicted byte
	localparam int MAX_PRINTED   = 40;

	logic clk;
	logic arst_n;

	mbre_cmd_if cmd_ch();
	mbre_enc_if enc_ch();
	mbre_cfg_if cfg_ch();

	msgpack_block_record_encoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.enc    (enc_ch),
		.cfg    (cfg_ch)
	);

	// encoder state as the testbench sees it
	logic [7:0]  lead_byte_now;
	logic [31:0] payload_left;
	result_t     expected_bytes[$];

	// pacing controls set by the test tasks for the sender and the output side
	bit sender_steady;
	bit steady_flow;
	int hold_request;

	// bookkeeping
	int fail_count;
	int items_sent;
	int records_started;
	int bytes_checked;
	int overflows_seen;
	int lead_writes;
	int stall_cycles;

	// free-running clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report_mismatch(string what);
		if (fail_count < MAX_PRINTED)
			$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	// header builder and payload counter: appends every byte one item causes
	function automatic void encode_item(item_t it);
		logic [7:0]  hdr[$];
		logic [31:0] dev_u;
		logic [31:0] len;
		int          i;
		if (it.action == ACT_START) begin
			dev_u = it.device_number;
			len   = it.payload_length;
			hdr.push_back(lead_byte_now);
			hdr.push_back(KEY_DEVNO);
			// shortest signed form of the device number
			if (dev_u <= 32'h0000_007F || dev_u >= 32'hFFFF_FFE0) begin
				hdr.push_back(dev_u[7:0]);
			end else if (dev_u >= 32'hFFFF_FF80) begin
				hdr.push_back(MK_INT8);
				hdr.push_back(dev_u[7:0]);
			end else if (dev_u <= 32'h0000_7FFF || dev_u >= 32'hFFFF_8000) begin
				hdr.push_back(MK_INT16);
				hdr.push_back(dev_u[15:8]);
				hdr.push_back(dev_u[7:0]);
			end else begin
				hdr.push_back(MK_INT32);
				for (i = 3; i >= 0; i--)
					hdr.push_back(dev_u[8*i +: 8]);
			end
			// offset always goes out as a full int64
			hdr.push_back(KEY_OFFSET);
			hdr.push_back(MK_INT64);
			for (i = 7; i >= 0; i--)
				hdr.push_back(it.block_offset[8*i +: 8]);
			// bin length header sized by the payload length
			hdr.push_back(KEY_LENGTH);
			if (len < 32'd256) begin
				hdr.push_back(MK_BIN8);
				hdr.push_back(len[7:0]);
			end else if (len < 32'd65536) begin
				hdr.push_back(MK_BIN16);
				hdr.push_back(len[15:8]);
				hdr.push_back(len[7:0]);
			end else begin
				hdr.push_back(MK_BIN32);
				for (i = 3; i >= 0; i--)
					hdr.push_back(len[8*i +: 8]);
			end
			payload_left = len;
			// an empty payload ends the record on the final header byte
			for (i = 0; i < hdr.size(); i++)
				expected_bytes.push_back('{hdr[i], (i == hdr.size() - 1) && (len == 0), 1'b0});
			records_started++;
		end else if (payload_left == 0) begin
			// surplus byte: flagged, nothing else changes
			expected_bytes.push_back('{8'h00, 1'b0, 1'b1});
		end else begin
			payload_left--;
			expected_bytes.push_back('{it.payload_byte, payload_left == 0, 1'b0});
		end
	endfunction

	function automatic item_t make_start(logic signed [31:0] dev, logic signed [63:0] off,
		logic [31:0] len);
		item_t it;
		it.action         = ACT_START;
		it.device_number  = dev;
		it.block_offset   = off;
		it.payload_length = len;
		it.payload_byte   = 8'($urandom);	// ignored on a start item
		return it;
	endfunction

	function automatic item_t make_data(logic [7:0] b);
		item_t it;
		// the record fields are noise here, the block must ignore them
		it.action         = ACT_DATA;
		it.device_number  = $urandom;
		it.block_offset   = {$urandom, $urandom};
		it.payload_length = $urandom;
		it.payload_byte   = b;
		return it;
	endfunction

	// offer one item, wait for its handshake, then predict what it causes
	task automatic send_item(item_t it);
		@(negedge clk);
		if (!sender_steady) begin
			while ($urandom_range(99) < 29) begin
				cmd_ch.valid = 1'b0;
				@(negedge clk);
			end
		end
		cmd_ch.action         = it.action;
		cmd_ch.device_number  = it.device_number;
		cmd_ch.block_offset   = it.block_offset;
		cmd_ch.payload_length = it.payload_length;
		cmd_ch.payload_byte   = it.payload_byte;
		cmd_ch.valid          = 1'b1;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		encode_item(it);
		items_sent++;
	endtask

	task automatic send_payload(int n);
		int k;
		for (k = 0; k < n; k++)
			send_item(make_data(8'($urandom)));
	endtask

	// sender goes quiet until every predicted byte has come out
	task automatic wait_for_drain();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// lead byte is written only with the encoder idle
	task automatic write_lead_byte(logic [7:0] value);
		wait_for_drain();
		@(negedge clk);
		cfg_ch.record_lead_byte = value;
		cfg_ch.valid            = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		lead_byte_now = value;
		lead_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic signed [31:0] pick_device();
		int v;
		case ($urandom_range(5))
			0: v = int'($urandom_range(127));
			1: v = -int'($urandom_range(32, 1));
			2: v = -int'($urandom_range(128, 33));
			3: v = $urandom_range(1) ? int'($urandom_range(32767, 128))
				: -int'($urandom_range(32768, 129));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_length();
		case ($urandom_range(19))
			15: return $urandom_range(255, 13);
			16: return $urandom_range(65535, 256);
			17: return $urandom_range(32'hFFFF_FFFF, 65536);
			18, 19: return $urandom;
			default: return $urandom_range(12);
		endcase
	endfunction

	// every device number form at its boundaries, offsets at their extremes
	task automatic test_device_forms();
		logic signed [31:0] devs[10];
		logic signed [63:0] offs[4];
		int k;
		devs = '{32'sd0, 32'sd127, 32'sd128, -32'sd32, -32'sd33, -32'sd128, -32'sd129,
			-32'sd32768, 32'sh7FFF_FFFF, 32'sh8000_0000};
		offs = '{64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000, 64'sd0, -64'sd1};
		// empty payload: last rides on the final header byte
		for (k = 0; k < 10; k++)
			send_item(make_start(devs[k], offs[k % 4], 32'd0));
	endtask

	// bin8, bin16 and bin32 headers at their limits, records left unfinished
	task automatic test_length_forms();
		send_item(make_start(-32'sd1, {$urandom, $urandom}, 32'd255));
		send_item(make_data(8'hFF));
		send_item(make_start(32'sd5, {$urandom, $urandom}, 32'd256));
		send_item(make_data(8'h00));
		send_item(make_start(32'sd300, {$urandom, $urandom}, 32'd65535));
		send_item(make_start(-32'sd70000, {$urandom, $urandom}, 32'd65536));
		send_item(make_start(32'sd1, {$urandom, $urandom}, 32'hFFFF_FFFF));
		send_item(make_data(8'hA5));
	endtask

	// one byte record closed by last, then a byte past the declared length
	task automatic test_surplus_byte();
		send_item(make_start(32'sd9, 64'sd4096, 32'd1));
		send_item(make_data(8'h5A));
		send_item(make_data(8'hC3));
	endtask

	// lead byte at both extremes
	task automatic test_lead_byte();
		write_lead_byte(8'h00);
		send_item(make_start(32'sd42, 64'sd512, 32'd0));
		write_lead_byte(8'hFF);
		send_item(make_start(-32'sd42, -64'sd512, 32'd2));
		send_payload(2);
	endtask

	// no idling on either side for a stretch of full records
	task automatic test_steady_stream();
		int r;
		wait_for_drain();
		sender_steady = 1'b1;
		steady_flow   = 1'b1;
		for (r = 0; r < 3; r++) begin
			send_item(make_start(pick_device(), {$urandom, $urandom}, 32'd20));
			send_payload(20);
		end
		sender_steady = 1'b0;
		steady_flow   = 1'b0;
	endtask

	// output held off while the sender keeps offering: the input must stall
	task automatic test_output_hold();
		wait_for_drain();
		sender_steady = 1'b1;
		hold_request  = HOLD_CYCLES;
		send_item(make_start(pick_device(), {$urandom, $urandom}, 32'd40));
		send_payload(40);
		sender_steady = 1'b0;
		// sender waits out everything before going on
		wait_for_drain();
		send_item(make_start(pick_device(), {$urandom, $urandom}, 32'd3));
		send_payload(3);
	endtask

	// mostly well-formed records with random content, some abandoned,
	// some with surplus bytes, plus stray payload bytes and lead byte changes
	task automatic test_random_records();
		int          start_count;
		int          n;
		int          next_write;
		logic [31:0] len;
		start_count = items_sent;
		next_write  = 60;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			if (items_sent - start_count >= next_write) begin
				write_lead_byte(8'($urandom));
				next_write += 60;
			end
			if ($urandom_range(11) == 0) begin
				send_item(make_data(8'($urandom)));
			end else begin
				len = pick_length();
				send_item(make_start(pick_device(), {$urandom, $urandom}, len));
				if (len > 12)
					n = $urandom_range(6);
				else if ($urandom_range(9) == 0)
					n = $urandom_range(len);	// may stop short, abandoned by the next start
				else
					n = len + (($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0);
				send_payload(n);
			end
		end
	endtask

	// output side ready: random, steady, or a counted hold-off
	initial begin : output_ready_drive
		int hold_left;
		hold_left    = 0;
		enc_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				enc_ch.ready = 1'b0;
				hold_left--;
			end else if (steady_flow) begin
				enc_ch.ready = 1'b1;
			end else begin
				enc_ch.ready = ($urandom_range(99) >= 29);
			end
		end
	end

	// every accepted byte against the oldest prediction
	always @(posedge clk) begin : check_output
		result_t want;
		if (arst_n && enc_ch.valid && enc_ch.ready) begin
			bytes_checked++;
			if (enc_ch.overflow)
				overflows_seen++;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b overflow %0b",
					enc_ch.out_byte, enc_ch.last, enc_ch.overflow));
			end else begin
				want = expected_bytes.pop_front();
				if (enc_ch.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, predicted %02h",
						enc_ch.out_byte, want.out_byte));
				if (enc_ch.last !== want.last)
					report_mismatch($sformatf("last %0b, predicted %0b on byte %02h",
						enc_ch.last, want.last, want.out_byte));
				if (enc_ch.overflow !== want.overflow)
					report_mismatch($sformatf("overflow %0b, predicted %0b",
						enc_ch.overflow, want.overflow));
			end
		end
	end

	// stall watchdog: any handshake on any channel restarts the count
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (enc_ch.valid && enc_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles, %0d bytes still predicted",
				$time, STALL_LIMIT, expected_bytes.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		// all inputs known from time zero
		arst_n                  = 1'b0;
		cmd_ch.valid            = 1'b0;
		cmd_ch.action           = ACT_START;
		cmd_ch.device_number    = '0;
		cmd_ch.block_offset     = '0;
		cmd_ch.payload_length   = '0;
		cmd_ch.payload_byte     = '0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.record_lead_byte = '0;
		sender_steady           = 1'b0;
		steady_flow             = 1'b0;
		hold_request            = 0;
		fail_count              = 0;
		items_sent              = 0;
		records_started         = 0;
		bytes_checked           = 0;
		overflows_seen          = 0;
		lead_writes             = 0;
		stall_cycles            = 0;
		lead_byte_now           = LEAD_RESET;
		payload_left            = '0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed part runs on the reset lead byte first
		test_device_forms();
		test_length_forms();
		test_surplus_byte();
		test_lead_byte();
		test_steady_stream();
		test_output_hold();
		test_random_records();

		wait_for_drain();

		$display("covered %0d items, %0d records, %0d lead byte writes",
			items_sent, records_started, lead_writes);
		$display("checked %0d output bytes, %0d of them surplus flags",
			bytes_checked, overflows_seen);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
src/mbre_pkg.sv
src/mbre_ifs.sv
src/mbre_hdr_build.sv
src/mbre_emit.sv
src/msgpack_block_record_encoder_unit.sv
sim/msgpack_block_record_encoder_unit_tb.sv
